### rtl/tdmh_pkg.sv
// ---------------------------------------------------------------------------
// tdmh_pkg: shared codes and types
// Operation and status codes, fixed widths and the result beat layout.
// ---------------------------------------------------------------------------
package tdmh_pkg;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_UPDATE  = 3'd2,
        OP_FIRE    = 3'd3,
        OP_TIMEOUT = 3'd4,
        OP_READ    = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOTFND = 2'd2,
        ST_DUP    = 2'd3
    } t_status;

    localparam int OUT_TIME_W = 48;
    localparam int TIME_BITS  = 48;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int TAG_W      = 6;
    localparam int TAG_COUNT  = 2 ** TAG_W;

    typedef struct packed {
        logic [1:0]            status;
        logic [TAG_W-1:0]      tag;
        logic [OUT_TIME_W-1:0] time_value;
        logic [POS_W-1:0]      pos;
        logic [CNT_W-1:0]      cnt;
        logic                  last;
    } t_result;

endpackage

### rtl/tdmh_out_reg.sv
// ---------------------------------------------------------------------------
// tdmh_out_reg: result output register
// Holds one result beat until the downstream side takes it.
// ---------------------------------------------------------------------------
module tdmh_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tdmh_pkg::t_result i_res,
    output logic             o_ready,
    output logic             o_valid,
    output tdmh_pkg::t_result o_res,
    input  logic             i_ready
);
    import tdmh_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end
endmodule

### rtl/timer_deadline_min_heap.sv
// ---------------------------------------------------------------------------
// timer_deadline_min_heap: timer queue on a binary min-heap
//
//   channel | dir | beat contents
//   s_axis  | in  | op, job_tag, deadline, now
//   m_axis  | out | status, result_tag, time_value, heap_position, fired_count,
//           |     | tlast on the final beat of an item
//
// One operation at a time; the heap and the tag position table sit in
// memories with registered reads. An item passes look-up, decide, its
// sift and emit; a sift-up level reads and compares the parent, a
// sift-down level reads both children and compares. A fire repeats
// look-up, removal and emit for every expired job. Reset empties the heap
// and unschedules every tag. A stalled output holds the controller in emit.
// ---------------------------------------------------------------------------
module timer_deadline_min_heap #(
    parameter int CAPACITY = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] op, [8:3] job_tag, [56:9] deadline, [104:57] now, zero fill
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [7:2] result_tag, [55:8] time_value, [61:56] heap_position,
    // [68:62] fired_count, zero fill
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import tdmh_pkg::*;

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_LOOK   = 12'b000000000010,
        S_DECIDE = 12'b000000000100,
        S_ENT    = 12'b000000001000,
        S_LAST   = 12'b000000010000,
        S_UP_RD  = 12'b000000100000,
        S_UP_CMP = 12'b000001000000,
        S_DN_RD  = 12'b000010000000,
        S_DN_L   = 12'b000100000000,
        S_DN_R   = 12'b001000000000,
        S_PLACE  = 12'b010000000000,
        S_EMIT   = 12'b100000000000
    } t_state;

    logic [TIME_BITS-1:0] m_dl [CAPACITY];
    logic [TAG_W-1:0]     m_tg [CAPACITY];
    logic [IW-1:0]        m_pos [TAG_COUNT];

    logic [TAG_COUNT-1:0] r_sched;
    logic [IW-1:0]        r_size;
    t_state               r_st;
    t_op                  r_op;
    logic [TAG_W-1:0]     r_itag;
    logic [TIME_BITS-1:0] r_idl, r_now;
    logic [TIME_BITS-1:0] r_d;
    logic [TAG_W-1:0]     r_t;
    logic [TIME_BITS-1:0] r_old;
    logic [IW-1:0]        r_i, r_c;
    logic [TIME_BITS-1:0] r_cd;
    logic [TAG_W-1:0]     r_ct;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic                 r_nomv;
    t_result              r_res;

    logic [IW-1:0]        rd_a;
    logic [TIME_BITS-1:0] r_rdl;
    logic [TAG_W-1:0]     r_rtg;
    logic [IW-1:0]        r_rpos;
    logic                 wr_en;
    logic [IW-1:0]        wr_a;
    logic [TIME_BITS-1:0] wr_d;
    logic [TAG_W-1:0]     wr_t;

    logic    res_v, res_rdy;
    t_result ores;

    logic acc;
    assign s_axis_tready = (r_st == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [2:0]           in_op;
    logic [TAG_W-1:0]     in_tag;
    logic [TIME_BITS-1:0] in_dl, in_now;
    assign in_op  = s_axis_tdata[2:0];
    assign in_tag = s_axis_tdata[8:3];
    assign in_dl  = s_axis_tdata[56:9];
    assign in_now = s_axis_tdata[104:57];

    always_ff @(posedge i_clk) begin
        r_rdl  <= m_dl[rd_a[AW-1:0]];
        r_rtg  <= m_tg[rd_a[AW-1:0]];
        r_rpos <= m_pos[r_itag];
        if (wr_en) begin
            m_dl[wr_a[AW-1:0]] <= wr_d;
            m_tg[wr_a[AW-1:0]] <= wr_t;
            m_pos[wr_t]        <= wr_a;
        end
    end

    logic [IW-1:0] par, lch, rch;
    assign par = (r_i - IW'(1)) >> 1;
    assign lch = IW'({r_i, 1'b1});
    assign rch = IW'(lch + IW'(1));

    logic found, expired;
    assign found   = r_sched[r_itag] && (r_rpos < r_size);
    assign expired = (r_size != '0) && (r_rdl <= r_now);

    logic [IW-1:0] rm_at;
    logic          rm_move;
    assign rm_at   = (r_st == S_DECIDE) ? '0 : r_i;
    assign rm_move = (r_size > IW'(1)) && (rm_at != r_size - IW'(1));

    logic                 right_wins;
    logic [TIME_BITS-1:0] sel_d;
    logic [TAG_W-1:0]     sel_t;
    logic [IW-1:0]        sel_c;
    assign right_wins = (rch < r_size) && (r_rdl < r_cd);
    assign sel_d = right_wins ? r_rdl : r_cd;
    assign sel_t = right_wins ? r_rtg : r_ct;
    assign sel_c = right_wins ? rch : r_c;

    t_state               n_st;
    logic [IW-1:0]        n_size, n_i, n_c;
    logic [TIME_BITS-1:0] n_d, n_cd, n_old;
    logic [TAG_W-1:0]     n_t, n_ct;
    logic [CNT_W-1:0]     n_cnt;
    logic [TAG_COUNT-1:0] n_sched;
    logic                 n_pend, n_nomv;
    t_result              n_res;
    logic                 do_rm;

    always_comb begin
        n_st = r_st; n_size = r_size; n_sched = r_sched; n_i = r_i; n_c = r_c;
        n_d = r_d; n_t = r_t; n_old = r_old; n_cd = r_cd; n_ct = r_ct;
        n_cnt = r_cnt; n_pend = r_pend; n_nomv = r_nomv; n_res = r_res;
        rd_a = '0; wr_en = 1'b0; wr_a = r_i; wr_d = r_d; wr_t = r_t;
        res_v = 1'b0; do_rm = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (acc) begin
                    n_cnt = '0; n_pend = 1'b0; n_st = S_LOOK;
                end
            end
            S_LOOK: begin
                rd_a = '0; n_st = S_DECIDE;
            end
            S_DECIDE: begin
                n_res = '0; n_res.tag = r_itag; n_res.last = 1'b1;
                n_nomv = 1'b0; n_st = S_EMIT;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_sched[r_itag]) n_res.status = ST_DUP;
                        else if (r_size >= IW'(CAPACITY)) n_res.status = ST_FULL;
                        else begin
                            n_sched[r_itag] = 1'b1;
                            n_size = r_size + IW'(1);
                            n_i = r_size; n_d = r_idl; n_t = r_itag;
                            n_st = S_UP_RD;
                        end
                    end
                    OP_DELETE, OP_UPDATE, OP_READ: begin
                        if (!found) n_res.status = ST_NOTFND;
                        else begin
                            n_i = r_rpos; rd_a = r_rpos; n_st = S_ENT;
                        end
                    end
                    OP_FIRE: begin
                        n_res.tag = '0;
                        if (expired && r_pend) begin
                            n_res = r_res;
                        end else if (expired) begin
                            n_i = '0; n_cnt = r_cnt + CNT_W'(1);
                            n_res.tag = r_rtg; n_res.cnt = r_cnt + CNT_W'(1);
                            n_res.last = 1'b0;
                            do_rm = 1'b1;
                        end else if (r_pend) begin
                            n_res = r_res; n_res.last = 1'b1;
                        end
                    end
                    OP_TIMEOUT: begin
                        if (r_size == '0) begin
                            n_res.status = ST_NOTFND; n_res.tag = '0;
                        end else begin
                            n_res.tag = r_rtg;
                            n_res.time_value = (r_rdl > r_now) ? r_rdl - r_now : '0;
                        end
                    end
                    OP_CLEAR: begin
                        n_res.tag = '0; n_size = '0; n_sched = '0;
                    end
                    OP_NONE: begin
                        n_res.tag = '0; n_res.status = ST_NOTFND;
                    end
                endcase
            end
            S_ENT: begin
                if (r_op == OP_READ) begin
                    n_res.time_value = r_rdl; n_st = S_EMIT;
                end else if (r_op == OP_UPDATE) begin
                    n_d = r_idl; n_t = r_rtg;
                    n_st = (r_idl < r_rdl) ? S_UP_RD : S_DN_RD;
                end else begin
                    do_rm = 1'b1;
                end
            end
            S_LAST: begin
                n_d = r_rdl; n_t = r_rtg;
                n_st = (r_rdl < r_old) ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD: begin
                if (r_i == '0) n_st = S_PLACE;
                else begin
                    rd_a = par; n_st = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_d < r_rdl) begin
                    wr_en = 1'b1; wr_a = r_i; wr_d = r_rdl; wr_t = r_rtg;
                    n_i = par; n_st = S_UP_RD;
                end else begin
                    n_st = S_PLACE;
                end
            end
            S_DN_RD: begin
                if (r_i >= (r_size >> 1)) n_st = S_PLACE;
                else begin
                    rd_a = lch; n_st = S_DN_L;
                end
            end
            S_DN_L: begin
                n_cd = r_rdl; n_ct = r_rtg; n_c = lch;
                rd_a = (rch < r_size) ? rch : lch;
                n_st = S_DN_R;
            end
            S_DN_R: begin
                if (r_d < sel_d) n_st = S_PLACE;
                else begin
                    wr_en = 1'b1; wr_a = r_i; wr_d = sel_d; wr_t = sel_t;
                    n_i = sel_c; n_st = S_DN_RD;
                end
            end
            S_PLACE: begin
                wr_en = !r_nomv; wr_a = r_i; wr_d = r_d; wr_t = r_t;
                if (r_op == OP_FIRE) begin
                    n_pend = 1'b1; n_st = S_LOOK;
                end else begin
                    if (r_op != OP_DELETE) n_res.pos = POS_W'(r_i);
                    n_st = S_EMIT;
                end
            end
            S_EMIT: begin
                res_v = 1'b1;
                if (res_rdy) begin
                    if (r_res.last) n_st = S_IDLE;
                    else begin
                        n_pend = 1'b0; n_st = S_LOOK;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
        if (do_rm) begin
            n_sched[r_rtg] = 1'b0;
            n_size = r_size - IW'(1);
            n_old = r_rdl;
            if (rm_move) begin
                rd_a = r_size - IW'(1); n_st = S_LAST;
            end else begin
                n_nomv = 1'b1; n_st = S_PLACE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_size <= '0; r_sched <= '0;
        end else begin
            r_st <= n_st; r_size <= n_size; r_sched <= n_sched;
        end
        if (acc) begin
            r_op <= t_op'(in_op); r_itag <= in_tag; r_idl <= in_dl; r_now <= in_now;
        end
        r_i <= n_i; r_c <= n_c; r_d <= n_d; r_t <= n_t; r_old <= n_old;
        r_cd <= n_cd; r_ct <= n_ct; r_cnt <= n_cnt; r_pend <= n_pend;
        r_nomv <= n_nomv; r_res <= n_res;
    end

    tdmh_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_v),
        .i_res   (r_res),
        .o_ready (res_rdy),
        .o_valid (m_axis_tvalid),
        .o_res   (ores),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {3'b0, ores.cnt, ores.pos, ores.time_value, ores.tag, ores.status};
    assign m_axis_tlast = ores.last;
endmodule

### rtl/tdmh_checker.sv
// ---------------------------------------------------------------------------
// tdmh_checker: port-level checks
// Output stability under stall, valid low after reset, zero pad, busy input.
// ---------------------------------------------------------------------------
module tdmh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [71:0]  m_axis_tdata,
    input logic         m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:69] == 3'b0)
        else $error("pad bits set");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");
endmodule

bind timer_deadline_min_heap tdmh_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
